// ===== src/sgam_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgam_pkg: shared types and constants of the saturating gain audio mixer
// Item formats, command and status bundles, register indexes and limits.
// ----------------------------------------------------------------------------
package sgam_pkg;

  // default parameter values
  localparam int GAIN_FRAC_BITS_DEF = 12;
  localparam int ACC_WIDTH_DEF      = 40;

  // output sample limits
  localparam int SAMPLE_MAX = 32767;
  localparam int SAMPLE_MIN = -32768;

  // configuration port
  localparam int          CFG_ADDR_W      = 3;
  localparam int          CFG_DATA_W      = 32;
  localparam logic [15:0] MASTER_GAIN_RST = 16'd4096;

  // register index, taken from paddr bit 2
  localparam logic REG_MASTER_GAIN_CH0 = 1'b0;
  localparam logic REG_MASTER_GAIN_CH1 = 1'b1;

  // sample_format codes
  localparam logic FMT_16BIT = 1'b0;
  localparam logic FMT_32BIT = 1'b1;

  // input item
  typedef struct packed {
    logic signed [31:0] source_sample;
    logic               sample_format;
    logic        [15:0] source_gain;
    logic               out_channel;
    logic               last_source;
  } sgam_in_t;

  // result item
  typedef struct packed {
    logic signed [15:0] mixed_sample;
    logic               clipped;
    logic               sample_channel;
  } sgam_out_t;

  // controller to datapath
  typedef struct packed {
    logic load_in;
    logic mac;
    logic mul;
    logic fin;
  } sgam_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic last;
  } sgam_sts_t;

endpackage

// ===== src/sgam_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgam_ctrl: mixer sequencer
// Steps each item through load, accumulate and, for the last contribution,
// master multiply and finish; owns both handshakes.
// ----------------------------------------------------------------------------
module sgam_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output sgam_pkg::sgam_cmd_t cmd,
  input  sgam_pkg::sgam_sts_t sts
);
  import sgam_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_MAC  = 4'b0010,
    S_MUL  = 4'b0100,
    S_FIN  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_MAC;
        end
      end
      S_MAC: begin
        cmd.mac   = 1'b1;
        state_nxt = sts.last ? S_MUL : S_IDLE;
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        // wait for room in the output register
        if (!out_valid_r || out_ready) begin
          cmd.fin   = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // output valid flag
  always_comb begin
    if (cmd.fin) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ===== src/sgam_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgam_dp: mixer datapath
// Sample conversion, source gain multiply-accumulate, split master gain
// multiply, floor scaling, saturation and the output register.
// ----------------------------------------------------------------------------
module sgam_dp #(
  parameter int GAIN_FRAC_BITS = sgam_pkg::GAIN_FRAC_BITS_DEF,
  parameter int ACC_WIDTH      = sgam_pkg::ACC_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  sgam_pkg::sgam_cmd_t cmd,
  output sgam_pkg::sgam_sts_t sts,
  input  sgam_pkg::sgam_in_t  in_data,
  input  logic [15:0]         master_gain_ch0,
  input  logic [15:0]         master_gain_ch1,
  output sgam_pkg::sgam_out_t out_data
);
  import sgam_pkg::*;

  localparam int PROD_W = 33;
  localparam int EXT_W  = (ACC_WIDTH > PROD_W) ? ACC_WIDTH : PROD_W;
  localparam int LO_W   = ACC_WIDTH / 2;
  localparam int HI_W   = ACC_WIDTH - LO_W;
  localparam int PL_W   = LO_W + 16;
  localparam int PH_W   = HI_W + 17;
  localparam int FULL_W = ACC_WIDTH + 17;
  localparam int SHIFT  = 2 * GAIN_FRAC_BITS;
  localparam logic signed [FULL_W-1:0] MAX_V = FULL_W'(SAMPLE_MAX);
  localparam logic signed [FULL_W-1:0] MIN_V = FULL_W'(SAMPLE_MIN);

  sgam_in_t                   in_r;
  logic signed [ACC_WIDTH-1:0] acc_r, acc_nxt;
  logic        [PL_W-1:0]     pl_r;
  logic signed [PH_W-1:0]     ph_r;
  sgam_out_t                  out_r, out_nxt;

  logic signed [15:0]         smp;
  logic signed [15:0]         quo;
  logic signed [PROD_W-1:0]   prod;
  logic signed [EXT_W-1:0]    prod_ext;
  logic        [15:0]         mg;
  logic signed [FULL_W-1:0]   ph_ext, pl_ext, full, scaled;

  // sample conversion, 32-bit form truncated toward zero
  always_comb begin
    quo = in_r.source_sample[31:16];
    if (in_r.source_sample[31] && (in_r.source_sample[15:0] != 16'd0)) begin
      quo = quo + 16'sd1;
    end
    if (in_r.sample_format == FMT_32BIT) begin
      smp = quo;
    end else begin
      smp = in_r.source_sample[15:0];
    end
  end

  // source gain product and wrapping accumulate
  assign prod     = PROD_W'(smp) * PROD_W'($signed({1'b0, in_r.source_gain}));
  assign prod_ext = EXT_W'(prod);
  assign acc_nxt  = acc_r + prod_ext[ACC_WIDTH-1:0];

  // master gain of the chosen channel
  assign mg = in_r.out_channel ? master_gain_ch1 : master_gain_ch0;

  // recombine partial products, floor shift, saturate
  always_comb begin
    ph_ext = FULL_W'(ph_r);
    pl_ext = $signed(FULL_W'(pl_r));
    full   = (ph_ext <<< LO_W) + pl_ext;
    scaled = full >>> SHIFT;
    out_nxt.sample_channel = in_r.out_channel;
    if (scaled > MAX_V) begin
      out_nxt.mixed_sample = 16'(SAMPLE_MAX);
      out_nxt.clipped      = 1'b1;
    end else if (scaled < MIN_V) begin
      out_nxt.mixed_sample = 16'(SAMPLE_MIN);
      out_nxt.clipped      = 1'b1;
    end else begin
      out_nxt.mixed_sample = scaled[15:0];
      out_nxt.clipped      = 1'b0;
    end
  end

  // accumulator, clears after each emission
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else if (cmd.fin) begin
      acc_r <= '0;
    end else if (cmd.mac) begin
      acc_r <= acc_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      in_r <= in_data;
    end
    if (cmd.mul) begin
      pl_r <= PL_W'(acc_r[LO_W-1:0]) * PL_W'(mg);
      ph_r <= PH_W'($signed(acc_r[ACC_WIDTH-1:LO_W])) * PH_W'($signed({1'b0, mg}));
    end
    if (cmd.fin) begin
      out_r <= out_nxt;
    end
  end

  assign sts.last = in_r.last_source;
  assign out_data = out_r;

endmodule

// ===== src/saturating_gain_audio_mixer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// saturating_gain_audio_mixer: gain, sum and saturate mixer for 16-bit audio
// Register file for the master gains plus sequencer and datapath.
// ----------------------------------------------------------------------------
// Each input item is one source contribution: it is converted to 16 bits,
// scaled by its Q4.12 source gain and added into a wrapping accumulator. An
// item without last_source goes through load and multiply-accumulate; the
// last contribution then has the master gain multiply split into two
// half-width partial products, which are then recombined, floor shifted and
// saturated into the output register; this finish step holds for as long
// as the previous result still waits in the output register. The next
// item is accepted while a result waits in that register. Master gains sit at
// byte address 0 (channel 0) and 4 (channel 1), reset to unity (4096), and
// must only be written while no item is in flight.
module saturating_gain_audio_mixer #(
  parameter int GAIN_FRAC_BITS = sgam_pkg::GAIN_FRAC_BITS_DEF,
  parameter int ACC_WIDTH      = sgam_pkg::ACC_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  sgam_pkg::sgam_in_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output sgam_pkg::sgam_out_t                 out_data,
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [sgam_pkg::CFG_ADDR_W-1:0]     cfg_paddr,
  input  logic [sgam_pkg::CFG_DATA_W-1:0]     cfg_pwdata,
  output logic [sgam_pkg::CFG_DATA_W-1:0]     cfg_prdata,
  output logic                                cfg_pready
);
  import sgam_pkg::*;

  logic [15:0] master_gain_ch0_r;
  logic [15:0] master_gain_ch1_r;
  logic        cfg_wr;
  logic        cfg_idx;
  sgam_cmd_t   cmd;
  sgam_sts_t   sts;

  // register write decode
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_idx    = cfg_paddr[2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      master_gain_ch0_r <= MASTER_GAIN_RST;
      master_gain_ch1_r <= MASTER_GAIN_RST;
    end else if (cfg_wr) begin
      if (cfg_idx == REG_MASTER_GAIN_CH0) begin
        master_gain_ch0_r <= cfg_pwdata[15:0];
      end else begin
        master_gain_ch1_r <= cfg_pwdata[15:0];
      end
    end
  end

  // register read
  always_comb begin
    if (cfg_idx == REG_MASTER_GAIN_CH1) begin
      cfg_prdata = CFG_DATA_W'(master_gain_ch1_r);
    end else begin
      cfg_prdata = CFG_DATA_W'(master_gain_ch0_r);
    end
  end

  sgam_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  sgam_dp #(
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS),
    .ACC_WIDTH      (ACC_WIDTH)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_data         (in_data),
    .master_gain_ch0 (master_gain_ch0_r),
    .master_gain_ch1 (master_gain_ch1_r),
    .out_data        (out_data)
  );

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking regression for the saturating gain audio mixer
// A predictor tracks the wrapping mix accumulator and both master gains, and
// every accepted source item updates it. Each emitted sample is checked field
// by field against the oldest predicted one. Stimulus runs through a set of
// master gain settings: a directed set of edge values, random mix sequences,
// and long runs that wrap the accumulator. Random stalls on both channels and
// two long output hold-offs are included.
// ----------------------------------------------------------------------------
module tb_top;
  import sgam_pkg::*;

  localparam int ACC_W         = ACC_WIDTH_DEF;
  localparam int FRAC_BITS     = GAIN_FRAC_BITS_DEF;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES   = 300;
  localparam int STALL_LIMIT   = 2000;

  // predictor plus store of predicted output samples
  class mix_scoreboard;
    logic [ACC_W-1:0] mix_acc;
    logic [15:0]      master_gain [2];
    sgam_out_t        expected_samples [$];
    int               mismatches;

    function new();
      mix_acc        = '0;
      master_gain[0] = MASTER_GAIN_RST;
      master_gain[1] = MASTER_GAIN_RST;
      mismatches     = 0;
    endfunction

    function void set_master_gain(logic ch, logic [15:0] gain);
      master_gain[ch] = gain;
    endfunction

    // fold one accepted source item into the accumulator
    function void add_contribution(sgam_in_t item);
      logic signed [15:0]      s16;
      logic signed [ACC_W-1:0] acc_s;
      longint                  sample;
      longint                  gain;
      longint                  prod;
      longint                  scaled;
      sgam_out_t               res;
      if (item.sample_format == FMT_16BIT) begin
        s16    = item.source_sample[15:0];
        sample = s16;
      end else begin
        // signed division truncates toward zero
        sample = longint'(item.source_sample) / 65536;
      end
      gain    = item.source_gain;
      prod    = sample * gain;
      mix_acc = mix_acc + prod[ACC_W-1:0];
      if (!item.last_source) return;
      // master scaling, floor shift, saturate
      acc_s  = mix_acc;
      scaled = acc_s;
      gain   = master_gain[item.out_channel];
      scaled = (scaled * gain) >>> (2 * FRAC_BITS);
      res.clipped = 1'b0;
      if (scaled > SAMPLE_MAX) begin
        scaled      = SAMPLE_MAX;
        res.clipped = 1'b1;
      end else if (scaled < SAMPLE_MIN) begin
        scaled      = SAMPLE_MIN;
        res.clipped = 1'b1;
      end
      res.mixed_sample   = 16'(scaled);
      res.sample_channel = item.out_channel;
      expected_samples.push_back(res);
      mix_acc = '0;
    endfunction

    // compare one emitted sample with the oldest prediction
    function void check_sample(sgam_out_t got);
      sgam_out_t want;
      if (expected_samples.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected sample: got sample %0d clip %0b ch %0b",
                   got.mixed_sample, got.clipped, got.sample_channel);
        return;
      end
      want = expected_samples.pop_front();
      if (got.mixed_sample !== want.mixed_sample || got.clipped !== want.clipped ||
          got.sample_channel !== want.sample_channel) begin
        mismatches++;
        if (mismatches <= 10)
          $display("sample mismatch: expected %0d clip %0b ch %0b, got %0d clip %0b ch %0b",
                   want.mixed_sample, want.clipped, want.sample_channel,
                   got.mixed_sample, got.clipped, got.sample_channel);
      end
    endfunction
  endclass

  logic                  clk         = 1'b0;
  logic                  rst_n       = 1'b0;
  logic                  in_valid    = 1'b0;
  logic                  in_ready;
  sgam_in_t              in_data     = '0;
  logic                  out_valid;
  logic                  out_ready   = 1'b0;
  sgam_out_t             out_data;
  logic                  cfg_psel    = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite  = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr   = '0;
  logic [CFG_DATA_W-1:0] cfg_pwdata  = '0;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  mix_scoreboard sb;
  bit            no_idle = 1'b0;
  int            stall_cycles = 0;
  int            samples_taken = 0;

  saturating_gain_audio_mixer u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #5 clk = ~clk;

  // output check and stall watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) sb.check_sample(out_data);
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
        $display("saturating_gain_audio_mixer regression: fail");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  // output side: random stalls plus long hold-offs to back up the mixer
  initial begin : sample_sink
    int stall;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 9);
      if (samples_taken == 30 || samples_taken == 200) stall += HOLD_CYCLES;
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      samples_taken++;
    end
  end

  // apb write: setup then access cycle
  task automatic gain_write(input logic ch, input logic [15:0] gain);
    @(posedge clk);
    cfg_psel   <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_paddr  <= {ch, 2'b00};
    cfg_pwdata <= {16'($urandom()), gain};
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    sb.set_master_gain(ch, gain);
  endtask

  task automatic set_gains(input logic [15:0] gain0, input logic [15:0] gain1);
    gain_write(REG_MASTER_GAIN_CH0, gain0);
    gain_write(REG_MASTER_GAIN_CH1, gain1);
  endtask

  // offer one item after a random gap, hold until accepted
  task automatic send_item(input sgam_in_t item);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.add_contribution(item);
  endtask

  // stop offering, wait for every predicted sample, then let the pipe settle
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_samples.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic sgam_in_t contribution(logic signed [31:0] sample, logic fmt,
                                            logic [15:0] gain, logic ch, logic last);
    sgam_in_t item;
    item.source_sample = sample;
    item.sample_format = fmt;
    item.source_gain   = gain;
    item.out_channel   = ch;
    item.last_source   = last;
    return item;
  endfunction

  function automatic sgam_in_t random_contribution(logic ch, logic last);
    sgam_in_t item;
    int       kind;
    kind = $urandom_range(0, 5);
    item.sample_format = (kind >= 3) ? FMT_32BIT : FMT_16BIT;
    case (kind)
      0: item.source_sample = $urandom();
      1: item.source_sample = int'($urandom_range(0, 4000)) - 2000;
      2: item.source_sample = $urandom_range(0, 1) ? 32'sd32767 : -32'sd32768;
      3: item.source_sample = $urandom();
      4: begin
        case ($urandom_range(0, 3))
          0: item.source_sample = 32'h7FFF_FFFF;
          1: item.source_sample = 32'h8000_0000;
          2: item.source_sample = {16'hFFFF, 16'($urandom())};
          default: item.source_sample = {16'h0000, 16'($urandom())};
        endcase
      end
      default: item.source_sample = int'($urandom_range(0, 262143)) - 131072;
    endcase
    case ($urandom_range(0, 4))
      0: item.source_gain = 16'($urandom_range(0, 65535));
      1: item.source_gain = 16'($urandom_range(2048, 6144));
      2: item.source_gain = 16'd0;
      3: item.source_gain = 16'hFFFF;
      default: item.source_gain = 16'($urandom_range(0, 1024));
    endcase
    item.out_channel = ch;
    item.last_source = last;
    return item;
  endfunction

  // edge samples, formats, rounding and channel switch at reset gains
  task automatic run_directed();
    send_item(contribution(32'sd32767, FMT_16BIT, 16'd4096, 1'b0, 1'b1));
    send_item(contribution(-32'sd32768, FMT_16BIT, 16'd4096, 1'b1, 1'b1));
    // upper bits ignored for 16-bit samples
    send_item(contribution(32'h7FFF_8000, FMT_16BIT, 16'd4096, 1'b0, 1'b1));
    send_item(contribution(32'h8000_7FFF, FMT_16BIT, 16'd4096, 1'b1, 1'b1));
    // 32-bit samples, truncation toward zero
    send_item(contribution(32'h7FFF_FFFF, FMT_32BIT, 16'd4096, 1'b0, 1'b1));
    send_item(contribution(32'h8000_0000, FMT_32BIT, 16'd4096, 1'b0, 1'b1));
    send_item(contribution(-32'sd65537, FMT_32BIT, 16'd4096, 1'b1, 1'b1));
    send_item(contribution(-32'sd1, FMT_32BIT, 16'd4096, 1'b0, 1'b1));
    send_item(contribution(32'sd65535, FMT_32BIT, 16'd4096, 1'b1, 1'b1));
    // gain extremes
    send_item(contribution(32'sd1000, FMT_16BIT, 16'd0, 1'b0, 1'b1));
    send_item(contribution(32'sd1000, FMT_16BIT, 16'hFFFF, 1'b1, 1'b1));
    // sums that clip both ways
    send_item(contribution(32'sd30000, FMT_16BIT, 16'd4096, 1'b0, 1'b0));
    send_item(contribution(32'sd30000, FMT_16BIT, 16'd4096, 1'b0, 1'b1));
    send_item(contribution(-32'sd30000, FMT_16BIT, 16'd8192, 1'b1, 1'b0));
    send_item(contribution(-32'sd30000, FMT_16BIT, 16'd4096, 1'b1, 1'b1));
    // floor rounding of tiny sums
    send_item(contribution(-32'sd1, FMT_16BIT, 16'd1, 1'b0, 1'b1));
    send_item(contribution(32'sd1, FMT_16BIT, 16'd1, 1'b1, 1'b1));
    // channel of the last item picks the master gain
    send_item(contribution(32'sd12345, FMT_16BIT, 16'd4096, 1'b0, 1'b0));
    send_item(contribution(-32'sd2345, FMT_32BIT, 16'd300, 1'b1, 1'b0));
    send_item(contribution(32'sd777, FMT_16BIT, 16'd5000, 1'b1, 1'b1));
  endtask

  // many full-scale products so the accumulator wraps
  task automatic run_wrap(input logic signed [31:0] sample, input int n_items);
    for (int i = 0; i < n_items; i++)
      send_item(contribution(sample, FMT_16BIT, 16'hFFFF, 1'b0, i == n_items - 1));
  endtask

  // mostly well-formed mix sequences, some with random last flags
  task automatic run_random(input int n_items);
    int   sent;
    int   n_src;
    logic ch;
    bit   noise;
    sgam_in_t item;
    sent = 0;
    while (sent < n_items) begin
      n_src = $urandom_range(1, 6);
      ch    = 1'($urandom_range(0, 1));
      noise = ($urandom_range(0, 9) == 0);
      for (int i = 0; i < n_src; i++) begin
        item = random_contribution(($urandom_range(0, 7) == 0) ? ~ch : ch, i == n_src - 1);
        if (noise) item.last_source = 1'($urandom_range(0, 1));
        send_item(item);
        sent++;
      end
    end
  endtask

  initial begin : stimulus
    logic [15:0] gain0;
    logic [15:0] gain1;
    sb = new();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    run_directed();
    drain();

    set_gains(16'hFFFF, 16'h0000);
    run_random(150);
    drain();

    set_gains(16'h0000, 16'hFFFF);
    run_random(150);
    drain();

    // back to unity, full speed, with wrapping runs
    set_gains(16'd4096, 16'd4096);
    no_idle = 1'b1;
    run_wrap(-32'sd32768, 262);
    run_wrap(32'sd32767, 270);
    run_random(100);
    no_idle = 1'b0;
    drain();

    for (int p = 0; p < 6; p++) begin
      gain0 = $urandom_range(0, 1) ? 16'($urandom()) : 16'($urandom_range(2048, 8192));
      gain1 = $urandom_range(0, 1) ? 16'($urandom()) : 16'($urandom_range(2048, 8192));
      set_gains(gain0, gain1);
      run_random(130);
      drain();
    end

    repeat (10) @(posedge clk);
    if (sb.mismatches == 0 && sb.expected_samples.size() == 0) begin
      $display("saturating_gain_audio_mixer regression: pass");
    end else begin
      $display("saturating_gain_audio_mixer regression: fail");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/sgam_pkg.sv
src/sgam_ctrl.sv
src/sgam_dp.sv
src/saturating_gain_audio_mixer.sv
test/tb_top.sv
